### hw/rtl/sfcd_pkg.sv
// Shared types, constants and helper functions for the sensor frame CRC decoder.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package sfcd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned TempCentiW = 15;
  localparam int unsigned HumCentiW  = 14;
  localparam int unsigned TempScaleW = 15;
  localparam int unsigned HumScaleW  = 14;
  localparam int unsigned TempProdW  = WordW + TempScaleW;
  localparam int unsigned HumProdW   = WordW + HumScaleW;

  localparam logic [ByteW-1:0] CrcInit = 8'hFF;
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;

  localparam logic [TempScaleW-1:0] TempScale  = 15'd17500;
  localparam logic [HumScaleW-1:0]  HumScale   = 14'd10000;
  localparam logic [WordW-1:0]      WordMax    = 16'hFFFF;
  localparam logic [WordW:0]        TempOffset = 17'd4500;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    POS_TEMP_MSB = 3'd0,
    POS_TEMP_LSB = 3'd1,
    POS_TEMP_CRC = 3'd2,
    POS_HUM_MSB  = 3'd3,
    POS_HUM_LSB  = 3'd4,
    POS_HUM_CRC  = 3'd5
  } pos_e;

  // One checked frame, handed from the byte parser to the scaling pipeline.
  typedef struct packed {
    status_e          status;
    logic [WordW-1:0] raw_temp;
    logic [WordW-1:0] raw_hum;
  } frame_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
    logic [ByteW-1:0] v;
    v = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

  // floor(x / 65535) for x below 2^31. With q0 = x >> 16 the remainder
  // estimate (x & 0xFFFF) + q0 stays below twice the divisor, so a single
  // compare-and-increment finishes the quotient.
  function automatic logic [WordW-1:0] div_word_max(input logic [TempProdW-1:0] x);
    logic [TempProdW-WordW-1:0] q0;
    logic [WordW:0]             r;
    q0 = x[TempProdW-1:WordW];
    r  = {1'b0, x[WordW-1:0]} + (WordW + 1)'(q0);
    if (r >= {1'b0, WordMax}) begin
      return WordW'(q0) + WordW'(1);
    end else begin
      return WordW'(q0);
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sensor_frame_crc_decode_core.sv
// Sensor frame CRC decoder top level: byte parser, frame queue and scaling pipeline.
// Throughput: one byte per cycle; a result leaves at most once every six bytes.
// Result path: the sixth byte of a frame completes the record, which passes the queue write,
// the multiply stage and the output register; output stalls back up into the queue.
// Input stalls only while the two-entry frame queue is full.
// Reset (rst_ni, asynchronous, active low) clears the frame position, CRC and all valids.
`default_nettype none

module sensor_frame_crc_decode_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [sfcd_pkg::ByteW-1:0]      rx_byte_i,
  input  wire logic                            frame_start_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [1:0]                      status_o,
  output      logic [sfcd_pkg::WordW-1:0]      raw_temperature_o,
  output      logic [sfcd_pkg::WordW-1:0]      raw_humidity_o,
  output      logic [sfcd_pkg::TempCentiW-1:0] temperature_centi_o,
  output      logic [sfcd_pkg::HumCentiW-1:0]  humidity_centi_o
);

  logic             push, q_full, q_valid, pop;
  sfcd_pkg::frame_t push_frame, q_frame;

  assign in_stall_o = q_full;

  sfcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (q_full),
    .rx_byte_i    (rx_byte_i),
    .frame_start_i(frame_start_i),
    .push_o       (push),
    .push_frame_o (push_frame)
  );

  sfcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_frame_i(push_frame),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .frame_o     (q_frame)
  );

  sfcd_scale u_scale (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (q_valid),
    .in_frame_i         (q_frame),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .raw_temperature_o  (raw_temperature_o),
    .raw_humidity_o     (raw_humidity_o),
    .temperature_centi_o(temperature_centi_o),
    .humidity_centi_o   (humidity_centi_o)
  );

endmodule

`default_nettype wire

### hw/rtl/sfcd_front.sv
// Byte parser: tracks frame position, runs the CRC-8 checks and assembles words.
// Depends on sfcd_pkg; pushes one checked frame record per completed frame.
`default_nettype none

module sfcd_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_stall_i,
  input  wire logic [sfcd_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic                      frame_start_i,
  output      logic                      push_o,
  output      sfcd_pkg::frame_t          push_frame_o
);

  sfcd_pkg::pos_e                 pos_q, pos_d, pos_cur;
  logic [sfcd_pkg::ByteW-1:0]     crc_q, crc_d;
  logic [sfcd_pkg::ByteW-1:0]     hold_q, hold_d;
  logic [sfcd_pkg::WordW-1:0]     temp_q, temp_d;
  logic [sfcd_pkg::WordW-1:0]     hum_q, hum_d;
  logic                           temp_ok_q, temp_ok_d;
  logic                           accept;

  assign accept = in_valid_i && !in_stall_i;

  // A start mark forces the byte to the temperature MSB slot; out-of-range
  // positions fall back to the frame start as well.
  always_comb begin
    if (frame_start_i || (pos_q > sfcd_pkg::POS_HUM_CRC)) begin
      pos_cur = sfcd_pkg::POS_TEMP_MSB;
    end else begin
      pos_cur = pos_q;
    end
  end

  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    hold_d       = hold_q;
    temp_d       = temp_q;
    hum_d        = hum_q;
    temp_ok_d    = temp_ok_q;
    push_o       = 1'b0;
    push_frame_o = '{status: sfcd_pkg::STATUS_OK, raw_temp: temp_q, raw_hum: hum_q};
    if (accept) begin
      if (pos_cur == sfcd_pkg::POS_HUM_CRC) begin
        pos_d = sfcd_pkg::POS_TEMP_MSB;
      end else begin
        pos_d = sfcd_pkg::pos_e'(pos_cur + 3'd1);
      end
      unique case (pos_cur)
        sfcd_pkg::POS_TEMP_MSB, sfcd_pkg::POS_HUM_MSB: begin
          crc_d  = sfcd_pkg::crc8_update(sfcd_pkg::CrcInit, rx_byte_i);
          hold_d = rx_byte_i;
        end
        sfcd_pkg::POS_TEMP_LSB: begin
          crc_d  = sfcd_pkg::crc8_update(crc_q, rx_byte_i);
          temp_d = {hold_q, rx_byte_i};
        end
        sfcd_pkg::POS_HUM_LSB: begin
          crc_d = sfcd_pkg::crc8_update(crc_q, rx_byte_i);
          hum_d = {hold_q, rx_byte_i};
        end
        sfcd_pkg::POS_TEMP_CRC: begin
          temp_ok_d = (crc_q == rx_byte_i);
          crc_d     = sfcd_pkg::CrcInit;
        end
        sfcd_pkg::POS_HUM_CRC: begin
          crc_d  = sfcd_pkg::CrcInit;
          push_o = 1'b1;
          if (!temp_ok_q) begin
            push_frame_o.status = sfcd_pkg::STATUS_TEMP_CRC;
          end else if (crc_q != rx_byte_i) begin
            push_frame_o.status = sfcd_pkg::STATUS_HUM_CRC;
          end else begin
            push_frame_o.status = sfcd_pkg::STATUS_OK;
          end
        end
        default: begin
          crc_d = crc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= sfcd_pkg::POS_TEMP_MSB;
      crc_q     <= sfcd_pkg::CrcInit;
      hold_q    <= '0;
      temp_q    <= '0;
      hum_q     <= '0;
      temp_ok_q <= 1'b1;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      hold_q    <= hold_d;
      temp_q    <= temp_d;
      hum_q     <= hum_d;
      temp_ok_q <= temp_ok_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sfcd_queue.sv
// Short frame queue between the byte parser and the scaling pipeline.
// Depends on sfcd_pkg for the frame record type and the queue depth.
`default_nettype none

module sfcd_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sfcd_pkg::frame_t push_frame_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             valid_o,
  output      sfcd_pkg::frame_t frame_o
);

  sfcd_pkg::frame_t                    entry_q [sfcd_pkg::QueueDepth];
  logic [sfcd_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [sfcd_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [sfcd_pkg::QueueCntW-1:0]      count_q, count_d;
  logic                                do_push, do_pop;

  localparam logic [sfcd_pkg::QueuePtrW-1:0] LastPtr =
    sfcd_pkg::QueuePtrW'(sfcd_pkg::QueueDepth - 1);
  localparam logic [sfcd_pkg::QueueCntW-1:0] FullCount =
    sfcd_pkg::QueueCntW'(sfcd_pkg::QueueDepth);

  assign full_o  = (count_q == FullCount);
  assign valid_o = (count_q != '0);
  assign frame_o = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_frame_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sfcd_scale.sv
// Scaling pipeline: multiply stage, then divide-by-65535 and offset into the output register.
// Depends on sfcd_pkg for the frame record, scale constants and the divide helper.
`default_nettype none

module sfcd_scale (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire sfcd_pkg::frame_t                in_frame_i,
  output      logic                            pop_o,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [1:0]                      status_o,
  output      logic [sfcd_pkg::WordW-1:0]      raw_temperature_o,
  output      logic [sfcd_pkg::WordW-1:0]      raw_humidity_o,
  output      logic [sfcd_pkg::TempCentiW-1:0] temperature_centi_o,
  output      logic [sfcd_pkg::HumCentiW-1:0]  humidity_centi_o
);

  // Multiply stage.
  logic                             s1_valid_q;
  sfcd_pkg::frame_t                 s1_frame_q;
  logic [sfcd_pkg::TempProdW-1:0]   s1_prod_t_q;
  logic [sfcd_pkg::HumProdW-1:0]    s1_prod_h_q;

  // Output register.
  logic                             out_valid_q;
  sfcd_pkg::status_e                out_status_q;
  logic [sfcd_pkg::WordW-1:0]       out_raw_t_q, out_raw_h_q;
  logic [sfcd_pkg::TempCentiW-1:0]  out_temp_q, out_temp_d;
  logic [sfcd_pkg::HumCentiW-1:0]   out_hum_q, out_hum_d;

  logic                             out_ready, s1_adv, out_load;
  logic [sfcd_pkg::WordW-1:0]       temp_quot, hum_quot;
  logic [sfcd_pkg::WordW:0]         temp_shift;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_adv    = !s1_valid_q || out_ready;
  assign out_load  = s1_valid_q && out_ready;
  assign pop_o     = in_valid_i && s1_adv;

  always_comb begin
    temp_quot  = sfcd_pkg::div_word_max(s1_prod_t_q);
    hum_quot   = sfcd_pkg::div_word_max(sfcd_pkg::TempProdW'(s1_prod_h_q));
    temp_shift = {1'b0, temp_quot} - sfcd_pkg::TempOffset;
    if (s1_frame_q.status == sfcd_pkg::STATUS_OK) begin
      out_temp_d = temp_shift[sfcd_pkg::TempCentiW-1:0];
      out_hum_d  = hum_quot[sfcd_pkg::HumCentiW-1:0];
    end else begin
      out_temp_d = '0;
      out_hum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_frame_q  <= in_frame_i;
      s1_prod_t_q <= sfcd_pkg::TempProdW'(in_frame_i.raw_temp) *
                     sfcd_pkg::TempProdW'(sfcd_pkg::TempScale);
      s1_prod_h_q <= sfcd_pkg::HumProdW'(in_frame_i.raw_hum) *
                     sfcd_pkg::HumProdW'(sfcd_pkg::HumScale);
    end
    if (out_load) begin
      out_status_q <= s1_frame_q.status;
      out_raw_t_q  <= s1_frame_q.raw_temp;
      out_raw_h_q  <= s1_frame_q.raw_hum;
      out_temp_q   <= out_temp_d;
      out_hum_q    <= out_hum_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign raw_temperature_o   = out_raw_t_q;
  assign raw_humidity_o      = out_raw_h_q;
  assign temperature_centi_o = out_temp_q;
  assign humidity_centi_o    = out_hum_q;

endmodule

`default_nettype wire

### hw/rtl/sfcd_checker.sv
// Port-level checks for the sensor frame CRC decoder, bound to the top level.
// Depends on sfcd_pkg for status codes and field widths.
`default_nettype none

module sfcd_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_i,
  input wire logic                            out_stall_i,
  input wire logic [1:0]                      status_i,
  input wire logic [sfcd_pkg::WordW-1:0]      raw_temperature_i,
  input wire logic [sfcd_pkg::TempCentiW-1:0] temperature_centi_i,
  input wire logic [sfcd_pkg::HumCentiW-1:0]  humidity_centi_i
);

  // A stalled result holds its valid, status, raw temperature and scaled temperature.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(status_i) &&
      $stable(raw_temperature_i) && $stable(temperature_centi_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i == sfcd_pkg::STATUS_OK ||
      status_i == sfcd_pkg::STATUS_TEMP_CRC || status_i == sfcd_pkg::STATUS_HUM_CRC)
    else $error("status code out of range");

  // Scaled fields are zero whenever a CRC check failed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != sfcd_pkg::STATUS_OK |->
      temperature_centi_i == '0 && humidity_centi_i == '0)
    else $error("scaled fields nonzero on CRC error");

  // A good frame stays within the sensor's scaled range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == sfcd_pkg::STATUS_OK |->
      humidity_centi_i <= sfcd_pkg::HumCentiW'(10000) &&
      $signed(temperature_centi_i) >= $signed(sfcd_pkg::TempCentiW'(-4500)) &&
      $signed(temperature_centi_i) <= $signed(sfcd_pkg::TempCentiW'(13000)))
    else $error("scaled value out of range");

endmodule

bind sensor_frame_crc_decode_core sfcd_checker u_sfcd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .status_i           (status_o),
  .raw_temperature_i  (raw_temperature_o),
  .temperature_centi_i(temperature_centi_o),
  .humidity_centi_i   (humidity_centi_o)
);

`default_nettype wire
